@@ rtl/epme_pkg.sv @@
package epme_pkg;

    // Default pool geometry.
    localparam int unsigned EPME_POOL_BYTES   = 256;
    localparam int unsigned EPME_HW_BYTES     = 256;
    localparam int unsigned EPME_TIMING_BYTES = 256;

    // Fixed widths and constants of the estimator.
    localparam int unsigned BINS        = 256;
    localparam int unsigned BIN_W       = 8;
    localparam int unsigned TEMP_W      = 32;
    localparam int unsigned LOG_FRAC_W  = 16;
    localparam int unsigned SCORE_W     = 13;
    localparam int unsigned SCORE_SCALE = 500;
    localparam int unsigned TRANS_SHIFT = 13;
    localparam int unsigned PASS_LEVEL  = 3000;
    localparam int unsigned SCORE_MAX   = 8191;

    typedef struct packed {
        logic [7:0] hw_byte;
        logic [7:0] timing_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         pool_byte;
        logic               done_res;
        logic [SCORE_W-1:0] entropy_score;
        logic               pass;
    } out_item_t;

    // Truncated Q16 log2, evaluated at elaboration for the pool size.
    function automatic longint unsigned log2_q16_c(input longint unsigned x);
        longint unsigned k;
        longint unsigned y;
        longint unsigned frac;
        int              b;
        k    = 0;
        frac = 0;
        if (x == 0) begin
            return 0;
        end
        while (k < 31 && (x >> (k + 1)) != 0) begin
            k++;
        end
        y = x << (30 - k);
        for (b = 0; b < 16; b++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                y    = y >> 1;
            end
        end
        return (k << 16) | frac;
    endfunction

endpackage

@@ rtl/entropy_pool_mixer_estimator.sv @@
// Entropy pool mixer and estimator.
// Input beats on s_valid/s_ready carry one pool position each: a hardware
// byte and a timing byte. The hardware byte is used while the position is
// below HW_BYTES and the timing byte while it is below TIMING_BYTES; both are
// XORed with the temperature byte chosen by position modulo 4, and the result
// is rotated left by 3. Every input beat yields exactly one output beat on
// m_valid/m_ready with that mixed byte. On the last position of a pool the
// output beat also carries done_res, the entropy score and the pass flag.
// An ordinary position reads its histogram bin from the block RAM in ST_IDLE
// and writes the incremented count back in ST_UPD; its output beat is loaded
// into the output register from ST_UPD, or from ST_HOLD while the receiver
// stalls. The last position adds a walk of the 256 bins (an occupied bin also
// takes the 16 squaring steps of the shared log2 multiplier) plus the states
// that start the walk, scale the score, divide it by the pool size through a
// reciprocal multiplication and load the output register.
// The output register parts the two sides: a new beat is accepted while an
// earlier result still waits, and a stalled receiver only holds the block
// once the next result is ready to be loaded.
// After reset the block clears the histogram RAM, one bin per cycle, with
// s_ready low; temperature writes are taken at any time.
module entropy_pool_mixer_estimator
    import epme_pkg::*;
#(
    parameter int unsigned POOL_BYTES   = EPME_POOL_BYTES,
    parameter int unsigned HW_BYTES     = EPME_HW_BYTES,
    parameter int unsigned TIMING_BYTES = EPME_TIMING_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [TEMP_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    // Widths that follow from the pool size.
    localparam int unsigned CW   = $clog2(POOL_BYTES + 1);   // bin count
    localparam int unsigned PW   = $clog2(POOL_BYTES);       // position
    localparam int unsigned TW   = $clog2(8 * POOL_BYTES);   // bit change count
    localparam int unsigned KW   = $clog2(CW);               // log2 integer part
    localparam int unsigned LW   = LOG_FRAC_W + KW;          // Q16 log2
    localparam int unsigned SW   = CW + LW;                  // sum of c*log2(c)
    localparam int unsigned NUMW = SW + 10;                  // scaled numerator
    localparam int unsigned NHW  = NUMW - LOG_FRAC_W;        // numerator / 65536
    localparam int unsigned RSH  = NHW + $clog2(POOL_BYTES); // reciprocal shift
    localparam int unsigned PRW  = 2 * NHW + 1;              // reciprocal product
    localparam int unsigned LCW  = $clog2(LOG_FRAC_W);

    // N * log2(N) in Q16.
    localparam logic [SW-1:0] WHOLE =
        SW'(longint'(POOL_BYTES) * log2_q16_c(longint'(POOL_BYTES)));

    // Reciprocal of the pool size, exact for every numerator below 2**NHW.
    localparam logic [NHW:0] RECIP =
        (NHW + 1)'((64'd1 << RSH) / 64'(POOL_BYTES) + 64'd1);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_UPD,
        ST_HOLD,
        ST_WSTART,
        ST_WCHK,
        ST_LOG,
        ST_MUL,
        ST_ACC,
        ST_DIFF,
        ST_NUM,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [PW-1:0]       pos_reg;
    logic [TW-1:0]       bc_reg;
    logic [BIN_W-1:0]    idx_reg;
    logic [BIN_W-1:0]    prev_reg;
    logic [BIN_W-1:0]    m_byte_reg;
    logic                last_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic [SW-1:0]       sum_reg;
    logic [CW-1:0]       c_reg;
    logic [KW-1:0]       log_k_reg;
    logic [30:0]         log_y_reg;
    logic [LOG_FRAC_W-1:0] log_frac_reg;
    logic [LCW-1:0]      log_cnt_reg;
    logic [SW-1:0]       prod_reg;
    logic [SW-1:0]       diff_reg;
    logic [NHW-1:0]      num_hi_reg;
    logic [NHW-1:0]      divq_reg;

    // Histogram RAM: one write port, one read port, registered read data.
    logic [CW-1:0]       hist_mem [BINS];
    logic [CW-1:0]       hist_rdata_reg;
    logic                hist_we;
    logic [BIN_W-1:0]    hist_waddr;
    logic [CW-1:0]       hist_wdata;
    logic [BIN_W-1:0]    hist_raddr;

    logic [1:0]          lane;
    logic [BIN_W-1:0]    mix;
    logic [BIN_W-1:0]    mix_rot;
    logic [BIN_W-1:0]    flip;
    logic [3:0]          flips;
    logic                is_last;
    logic                out_free;
    logic                out_load;
    logic [61:0]         sq;
    logic [31:0]         sq_top;
    logic [KW-1:0]       init_k;
    logic [30:0]         init_y;
    logic [SW:0]         num_base;
    logic [NUMW-1:0]     num;
    logic [PRW-1:0]      recip_prod;
    logic [SCORE_W-1:0]  score_val;

    always_comb begin
        // Mixing path for the beat on the input channel.
        lane = 2'(pos_reg);
        mix  = temp_reg[8 * lane +: 8];
        if (32'(pos_reg) < HW_BYTES) begin
            mix = mix ^ s_data.hw_byte;
        end
        if (32'(pos_reg) < TIMING_BYTES) begin
            mix = mix ^ s_data.timing_byte;
        end
        mix_rot = {mix[4:0], mix[7:5]};
        flip    = mix_rot ^ prev_reg;
        flips   = '0;
        for (int b = 0; b < BIN_W; b++) begin
            flips = flips + 4'(flip[b]);
        end
        is_last  = (pos_reg == PW'(POOL_BYTES - 1));
        out_free = !m_valid_reg || m_ready;
        out_load = out_free && ((state_reg inside {ST_UPD, ST_HOLD} && !last_reg)
                                || state_reg == ST_FIN);

        // One squaring step of the log2 fraction.
        sq     = 62'(log_y_reg) * 62'(log_y_reg);
        sq_top = sq[61:30];

        // Normalization of a nonzero bin count.
        init_k = '0;
        for (int b = 0; b < CW; b++) begin
            if (hist_rdata_reg[b]) begin
                init_k = KW'(b);
            end
        end
        init_y = 31'(hist_rdata_reg) << (5'd30 - 5'(init_k));

        // Numerator 500 * (diff + T * 8192); only its upper bits go on.
        num_base = (SW + 1)'(diff_reg) + ((SW + 1)'(bc_reg) << TRANS_SHIFT);
        num      = NUMW'(SCORE_SCALE) * NUMW'(num_base);

        // Division by the pool size as a multiplication by its reciprocal.
        recip_prod = PRW'(num_hi_reg) * PRW'(RECIP);

        score_val = (divq_reg > NHW'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                  : divq_reg[SCORE_W-1:0];

        // Histogram RAM port control.
        hist_we    = 1'b0;
        hist_waddr = idx_reg;
        hist_wdata = '0;
        hist_raddr = idx_reg;
        case (state_reg)
            ST_CLR: begin
                hist_we = 1'b1;
            end
            ST_IDLE: begin
                hist_raddr = mix_rot;
            end
            ST_UPD: begin
                hist_we    = 1'b1;
                hist_waddr = m_byte_reg;
                hist_wdata = hist_rdata_reg + CW'(1);
            end
            ST_WCHK: begin
                hist_we    = 1'b1;
                hist_raddr = idx_reg + BIN_W'(1);
            end
            ST_ACC: begin
                hist_raddr = idx_reg + BIN_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            temp_reg    <= '0;
            pos_reg     <= '0;
            bc_reg      <= '0;
            idx_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            sum_reg     <= '0;
            log_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                temp_reg <= cfg_wr_data;
            end
            // A new result may replace one that is taken in the same cycle.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    idx_reg <= idx_reg + BIN_W'(1);
                    if (idx_reg == BIN_W'(BINS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        pos_reg    <= is_last ? '0 : pos_reg + PW'(1);
                        if (pos_reg != '0) begin
                            bc_reg <= bc_reg + TW'(flips);
                        end
                        prev_reg   <= mix_rot;
                        m_byte_reg <= mix_rot;
                        last_reg   <= is_last;
                        state_reg  <= ST_UPD;
                    end
                end
                ST_UPD, ST_HOLD: begin
                    if (last_reg) begin
                        state_reg <= ST_WSTART;
                    end else if (out_free) begin
                        m_data_reg.pool_byte     <= m_byte_reg;
                        m_data_reg.done_res      <= 1'b0;
                        m_data_reg.entropy_score <= '0;
                        m_data_reg.pass          <= 1'b0;
                        state_reg                <= ST_IDLE;
                    end else begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_WSTART: begin
                    // Bin zero is read here, after the last count was written.
                    state_reg <= ST_WCHK;
                end
                ST_WCHK: begin
                    if (hist_rdata_reg == '0) begin
                        idx_reg <= idx_reg + BIN_W'(1);
                        if (idx_reg == BIN_W'(BINS - 1)) begin
                            state_reg <= ST_DIFF;
                        end
                    end else begin
                        c_reg        <= hist_rdata_reg;
                        log_k_reg    <= init_k;
                        log_y_reg    <= init_y;
                        log_frac_reg <= '0;
                        log_cnt_reg  <= '0;
                        state_reg    <= ST_LOG;
                    end
                end
                ST_LOG: begin
                    log_frac_reg <= {log_frac_reg[LOG_FRAC_W-2:0], sq_top[31]};
                    log_y_reg    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                    log_cnt_reg  <= log_cnt_reg + LCW'(1);
                    if (log_cnt_reg == LCW'(LOG_FRAC_W - 1)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= SW'(c_reg) * SW'({log_k_reg, log_frac_reg});
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    sum_reg <= sum_reg + prod_reg;
                    idx_reg <= idx_reg + BIN_W'(1);
                    if (idx_reg == BIN_W'(BINS - 1)) begin
                        state_reg <= ST_DIFF;
                    end else begin
                        state_reg <= ST_WCHK;
                    end
                end
                ST_DIFF: begin
                    // Truncation can push the sum past N*log2(N); clamp at zero.
                    diff_reg  <= (WHOLE > sum_reg) ? (WHOLE - sum_reg) : '0;
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    num_hi_reg <= num[NUMW-1:LOG_FRAC_W];
                    state_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    divq_reg  <= NHW'(recip_prod >> RSH);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_data_reg.pool_byte     <= m_byte_reg;
                        m_data_reg.done_res      <= 1'b1;
                        m_data_reg.entropy_score <= score_val;
                        m_data_reg.pass          <= (score_val >= SCORE_W'(PASS_LEVEL));
                        bc_reg                   <= '0;
                        sum_reg                  <= '0;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Each accepted beat needs its write-back cycle before the next read.
    a_rmw_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat accepted during histogram write-back");

    // Estimate fields are zero unless the beat closes a pool.
    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |-> (m_data.entropy_score == '0 && !m_data.pass))
        else $error("estimate fields set on an ordinary position");

    // The pass flag agrees with the score it belongs to.
    a_pass_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |->
            (m_data.pass == (m_data.entropy_score >= SCORE_W'(PASS_LEVEL))))
        else $error("pass flag disagrees with entropy score");

    // At most eight bit changes per position taken so far in this pool.
    a_flip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (32'(bc_reg) <= 32'(pos_reg) * 32'd8))
        else $error("bit change count exceeds positions seen");
`endif

endmodule
